// ===== rtl/ple_pkg.sv =====
// Package for the positional list engine.
// Field widths, command and status codes, parameter defaults. No dependencies.
package ple_pkg;

  localparam int CMD_W    = 2;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int WIDE_W   = 64;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SHOW   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SHOWN    = 3'd5;

endpackage

// ===== rtl/ple_if.sv =====
// Request and response channel interfaces for the positional list engine.
// Depends on ple_pkg for field widths.
interface ple_req_if;
  logic                                valid;
  logic                                ready;
  logic [ple_pkg::CMD_W-1:0]           cmd;
  logic [ple_pkg::POS_W-1:0]           position;
  logic signed [ple_pkg::DATA_W-1:0]   value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface ple_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [ple_pkg::STATUS_W-1:0]        status;
  logic signed [ple_pkg::DATA_W-1:0]   element;
  logic                                has_element;
  logic                                last;

  modport source (output valid, status, element, has_element, last, input ready);
  modport sink   (input valid, status, element, has_element, last, output ready);
endinterface

// ===== rtl/ple_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Read data holds when no read is issued. No dependencies.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// Positional list engine: ordered list of signed values kept in one RAM.
// Depends on ple_pkg, ple_req_if / ple_rsp_if and ple_ram.
//
//   channel | dir | payload                               | per request
//   req     | in  | cmd, position, value                  | one command
//   rsp     | out | status, element, has_element, last    | 1, or count on show (1 if empty)
//
// Insert, delete, find and show walk the list through the single RAM port, one entry
// per cycle, holding on show while the response slot is busy; find stops at its first
// match, and an append at the tail or a delete of the last entry walks nothing.
// Reset clears the element count; RAM contents are not cleared.
// A stalled response holds the engine; req is taken only when the engine is idle,
// while the previous response may still wait in the output register.
module positional_list_engine_unit #(
  parameter int CAPACITY    = ple_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = ple_pkg::VALUE_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  ple_req_if.sink  req,
  ple_rsp_if.source rsp
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS      = 3'd1;
  localparam logic [2:0] S_INS_LAST = 3'd2;
  localparam logic [2:0] S_DEL      = 3'd3;
  localparam logic [2:0] S_FIND     = 3'd4;
  localparam logic [2:0] S_SHOW     = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  logic [2:0]                    state, state_next;
  logic [CW-1:0]                 count, count_next;
  logic [AW-1:0]                 idx, idx_next;
  logic [AW-1:0]                 at, at_next;
  logic [VALUE_WIDTH-1:0]        val_q, val_next;
  logic [ple_pkg::STATUS_W-1:0]  res_status, res_next;

  logic                          out_valid;
  logic [ple_pkg::STATUS_W-1:0]  out_status_q;
  logic signed [ple_pkg::DATA_W-1:0] out_elem_q;
  logic                          out_has_q, out_last_q;

  logic                          load_out;
  logic [ple_pkg::STATUS_W-1:0]  out_status;
  logic signed [ple_pkg::DATA_W-1:0] out_elem;
  logic                          out_has, out_last;

  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0]        ram_wdata, rd_data;

  logic [CMPW-1:0]               pos_ext, cnt_ext;
  logic [AW-1:0]                 at_in, cnt_m1;
  logic signed [ple_pkg::WIDE_W-1:0] in_wide, show_wide;
  logic [VALUE_WIDTH-1:0]        in_val;
  logic                          slot_free;
  logic                          ins_bad, del_bad, is_full;

  ple_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign pos_ext   = CMPW'(req.position);
  assign cnt_ext   = CMPW'(count);
  assign at_in     = AW'(pos_ext - CMPW'(1));
  assign cnt_m1    = AW'(count - CW'(1));
  assign in_wide   = ple_pkg::WIDE_W'(req.value);
  assign in_val    = in_wide[VALUE_WIDTH-1:0];
  // stored value sign extended from its own width, then cut to the port
  assign show_wide = ple_pkg::WIDE_W'(signed'(rd_data));
  assign slot_free = !out_valid || rsp.ready;
  assign ins_bad   = (pos_ext == '0) || (pos_ext > cnt_ext + CMPW'(1));
  assign del_bad   = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign is_full   = (count == CW'(CAPACITY));

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status_q;
  assign rsp.element     = out_elem_q;
  assign rsp.has_element = out_has_q;
  assign rsp.last        = out_last_q;

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    at_next    = at;
    val_next   = val_q;
    res_next   = res_status;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = rd_data;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    load_out   = 1'b0;
    out_status = ple_pkg::ST_DONE;
    out_elem   = '0;
    out_has    = 1'b0;
    out_last   = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          val_next = in_val;
          at_next  = at_in;
          unique case (req.cmd)
            ple_pkg::CMD_INSERT: begin
              if (ins_bad) begin
                res_next   = ple_pkg::ST_BADPOS;
                state_next = S_RESP;
              end else if (is_full) begin
                res_next   = ple_pkg::ST_FULL;
                state_next = S_RESP;
              end else if (pos_ext - CMPW'(1) == cnt_ext) begin
                // append at the tail: nothing to shift
                ram_we     = 1'b1;
                ram_waddr  = at_in;
                ram_wdata  = in_val;
                count_next = count + CW'(1);
                res_next   = ple_pkg::ST_DONE;
                state_next = S_RESP;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = cnt_m1;
                idx_next   = cnt_m1;
                state_next = S_INS;
              end
            end
            ple_pkg::CMD_DELETE: begin
              if (del_bad) begin
                res_next   = ple_pkg::ST_BADPOS;
                state_next = S_RESP;
              end else if (pos_ext == cnt_ext) begin
                count_next = count - CW'(1);
                res_next   = ple_pkg::ST_DONE;
                state_next = S_RESP;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = at_in + AW'(1);
                idx_next   = at_in + AW'(1);
                state_next = S_DEL;
              end
            end
            ple_pkg::CMD_FIND: begin
              if (count == '0) begin
                res_next   = ple_pkg::ST_NOTFOUND;
                state_next = S_RESP;
              end else begin
                ram_re     = 1'b1;
                idx_next   = '0;
                state_next = S_FIND;
              end
            end
            ple_pkg::CMD_SHOW: begin
              if (count == '0) begin
                res_next   = ple_pkg::ST_DONE;
                state_next = S_RESP;
              end else begin
                ram_re     = 1'b1;
                idx_next   = '0;
                state_next = S_SHOW;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        // move entry idx to idx+1 while fetching idx-1, until idx reaches at
        ram_we    = 1'b1;
        ram_waddr = idx + AW'(1);
        if (idx == at) begin
          state_next = S_INS_LAST;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx - AW'(1);
          idx_next  = idx - AW'(1);
        end
      end
      S_INS_LAST: begin
        ram_we     = 1'b1;
        ram_waddr  = at;
        ram_wdata  = val_q;
        count_next = count + CW'(1);
        res_next   = ple_pkg::ST_DONE;
        state_next = S_RESP;
      end
      S_DEL: begin
        ram_we    = 1'b1;
        ram_waddr = idx - AW'(1);
        if (idx == cnt_m1) begin
          count_next = count - CW'(1);
          res_next   = ple_pkg::ST_DONE;
          state_next = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx + AW'(1);
          idx_next  = idx + AW'(1);
        end
      end
      S_FIND: begin
        if (rd_data == val_q) begin
          res_next   = ple_pkg::ST_FOUND;
          state_next = S_RESP;
        end else if (idx == cnt_m1) begin
          res_next   = ple_pkg::ST_NOTFOUND;
          state_next = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx + AW'(1);
          idx_next  = idx + AW'(1);
        end
      end
      S_SHOW: begin
        // rd_data holds entry idx until the output slot frees up
        if (slot_free) begin
          load_out   = 1'b1;
          out_status = ple_pkg::ST_SHOWN;
          out_elem   = show_wide[ple_pkg::DATA_W-1:0];
          out_has    = 1'b1;
          out_last   = (idx == cnt_m1);
          if (idx == cnt_m1) begin
            state_next = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx + AW'(1);
            idx_next  = idx + AW'(1);
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          load_out   = 1'b1;
          out_status = res_status;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    at         <= at_next;
    val_q      <= val_next;
    res_status <= res_next;
    if (load_out) begin
      out_status_q <= out_status;
      out_elem_q   <= out_elem;
      out_has_q    <= out_has;
      out_last_q   <= out_last;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |-> count == $past(count) + CW'(1) ||
                              count == $past(count) - CW'(1))
    else $error("element count moved by more than one");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE)
    else $error("accepted request left the engine idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !out_valid || rsp.ready)
    else $error("response register overwritten while stalled");

  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("store read and written at the same entry");
`endif

endmodule

// ===== sim/positional_list_engine_unit_checker.sv =====
// Response checker for the positional list engine: keeps a shadow copy of the list,
// predicts the responses of each accepted request and compares them in order.
// Depends on ple_pkg and the ple_req_if / ple_rsp_if interfaces.
module positional_list_engine_unit_checker (
  input  logic clk,
  input  logic rst,
  ple_req_if   req,
  ple_rsp_if   rsp,
  output int   fail_count,
  output int   pending,
  output int   checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] element;
    logic                     has_element;
    logic                     last;
  } outcome_t;

  logic signed [DATA_W-1:0] shadow_list[$];
  outcome_t                 due_rsp[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic void push_outcome(logic [STATUS_W-1:0] st, logic signed [DATA_W-1:0] el,
                                       logic has, logic lst);
    outcome_t o;
    o.status      = st;
    o.element     = el;
    o.has_element = has;
    o.last        = lst;
    due_rsp.push_back(o);
  endfunction

  function automatic void apply_command(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                                        logic signed [DATA_W-1:0] val);
    int len;
    int p;
    bit hit;
    len = shadow_list.size();
    p   = int'(pos);
    hit = 1'b0;
    case (op)
      CMD_INSERT: begin
        // bad position wins over full
        if (p < 1 || p > len + 1) begin
          push_outcome(ST_BADPOS, '0, 1'b0, 1'b1);
        end else if (len >= CAPACITY_DEF) begin
          push_outcome(ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          shadow_list.insert(p - 1, val);
          push_outcome(ST_DONE, '0, 1'b0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (p < 1 || p > len) begin
          push_outcome(ST_BADPOS, '0, 1'b0, 1'b1);
        end else begin
          shadow_list.delete(p - 1);
          push_outcome(ST_DONE, '0, 1'b0, 1'b1);
        end
      end
      CMD_FIND: begin
        foreach (shadow_list[i]) if (shadow_list[i] == val) hit = 1'b1;
        push_outcome(hit ? ST_FOUND : ST_NOTFOUND, '0, 1'b0, 1'b1);
      end
      CMD_SHOW: begin
        if (len == 0) begin
          push_outcome(ST_DONE, '0, 1'b0, 1'b1);
        end else begin
          foreach (shadow_list[i]) push_outcome(ST_SHOWN, shadow_list[i], 1'b1, i == len - 1);
        end
      end
    endcase
  endfunction

  function automatic void check_response(outcome_t got);
    outcome_t want;
    if (due_rsp.size() == 0) begin
      $error("unexpected response: status %0d element %0d has_element %0d last %0d",
             got.status, got.element, got.has_element, got.last);
      fail_count++;
      return;
    end
    want = due_rsp.pop_front();
    checked++;
    if (got.status !== want.status) begin
      $error("status mismatch: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.element !== want.element) begin
      $error("element mismatch: expected %0d, got %0d", want.element, got.element);
      fail_count++;
    end
    if (got.has_element !== want.has_element) begin
      $error("has_element mismatch: expected %0d, got %0d", want.has_element, got.has_element);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last mismatch: expected %0d, got %0d", want.last, got.last);
      fail_count++;
    end
  endfunction

  // A response may leave at the same edge as the next request is taken; it
  // always belongs to an older request, so it is checked first.
  always @(posedge clk) begin
    if (rst) begin
      shadow_list.delete();
      due_rsp.delete();
    end else begin
      if (rsp.valid && rsp.ready)
        check_response('{rsp.status, rsp.element, rsp.has_element, rsp.last});
      if (req.valid && req.ready)
        apply_command(req.cmd, req.position, req.value);
    end
    pending = due_rsp.size();
  end

endmodule

// ===== sim/positional_list_engine_unit_tb.sv =====
// Top testbench for positional_list_engine_unit: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on ple_pkg, the channel
// interfaces, the engine and positional_list_engine_unit_checker.
module positional_list_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_CMDS  = 480;
  localparam int PHASE_LEN    = 120;
  localparam int SEGMENT_LEN  = 80;
  localparam int DRAIN_CYCLES = CAPACITY_DEF + 16;
  // ~500 requests, each worst case 64 responses behind long stalls, plus walk time
  localparam int CYCLE_LIMIT  = 3_000_000;

  logic clk = 1'b0;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   list_len;
  int   cmds_sent;
  int   cycle_cnt = 0;
  int   fail_count;
  int   pending;
  int   checked;

  ple_req_if req_ch();
  ple_rsp_if rsp_ch();

  positional_list_engine_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  positional_list_engine_unit_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) rsp_ch.ready = !rst && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid    = 1'b0;
      req_ch.cmd      = CMD_W'($urandom);
      req_ch.position = POS_W'($urandom);
      req_ch.value    = $urandom;
      @(negedge clk);
    end
    req_ch.valid    = 1'b1;
    req_ch.cmd      = op;
    req_ch.position = pos;
    req_ch.value    = val;
    // track the list length only to steer positions
    case (op)
      CMD_INSERT: if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY_DEF) list_len++;
      CMD_DELETE: if (pos >= 1 && pos <= list_len) list_len--;
      default: ;
    endcase
    cmds_sent++;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // extremes and repeats so finds hit often
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return -1;
      2:       return 32'sh7FFF_FFFF;
      3:       return 32'sh8000_0000;
      4:       return 1;
      5:       return 32'sh5A5A_A5A5;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_cmd(input int target);
    int               r;
    int               ins_w;
    int               del_w;
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] pos;
    ins_w = (list_len < target) ? 80 : 25;
    del_w = (list_len < target) ? 5 : 50;
    r = $urandom_range(99);
    if (r < ins_w)              op = CMD_INSERT;
    else if (r < ins_w + del_w) op = CMD_DELETE;
    else if (r < 92)            op = CMD_FIND;
    else                        op = CMD_SHOW;
    if ($urandom_range(99) < 15)
      pos = POS_W'($urandom);
    else if (op == CMD_DELETE)
      pos = POS_W'($urandom_range(list_len, 1));
    else
      pos = POS_W'($urandom_range(list_len + 1, 1));
    send_cmd(op, pos, pick_value());
  endtask

  initial begin
    int target;
    target          = 0;
    req_ch.valid    = 1'b0;
    req_ch.cmd      = CMD_INSERT;
    req_ch.position = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    list_len        = 0;
    cmds_sent       = 0;
    rst             = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty list corners
    send_cmd(CMD_SHOW,   0, 0);
    send_cmd(CMD_DELETE, 1, 0);
    send_cmd(CMD_FIND,   0, 0);
    send_cmd(CMD_INSERT, 0, 5);
    send_cmd(CMD_INSERT, 2, 5);
    // build at head, tail and middle with extreme values
    send_cmd(CMD_INSERT, 1, 32'sh7FFF_FFFF);
    send_cmd(CMD_INSERT, 1, 32'sh8000_0000);
    send_cmd(CMD_INSERT, 3, 0);
    send_cmd(CMD_INSERT, 2, -1);
    send_cmd(CMD_FIND,   0, 32'sh8000_0000);
    send_cmd(CMD_FIND,   9, 0);
    send_cmd(CMD_FIND,   0, 5);
    send_cmd(CMD_SHOW,   0, 0);
    // bad positions on a non-empty list
    send_cmd(CMD_DELETE, 0, 0);
    send_cmd(CMD_DELETE, 5, 0);
    send_cmd(CMD_DELETE, 127, 0);
    send_cmd(CMD_INSERT, 127, 3);
    send_cmd(CMD_INSERT, 6, 3);
    // tail, head, then check what is left
    send_cmd(CMD_DELETE, 4, 0);
    send_cmd(CMD_DELETE, 1, 0);
    send_cmd(CMD_SHOW,   0, 0);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (i % PHASE_LEN == 0) begin
        case ((i / PHASE_LEN) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
          default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
      end
      // swing the list between full, empty and random fill levels
      if (i % SEGMENT_LEN == 0) begin
        case ((i / SEGMENT_LEN) % 3)
          0:       target = CAPACITY_DEF;
          1:       target = 0;
          default: target = $urandom_range(CAPACITY_DEF);
        endcase
      end
      random_cmd(target);
    end
    req_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d list commands over four idle/stall mixes, filling and draining the list.",
             cmds_sent);
    $display("Checked %0d responses against the shadow list, %0d mismatches.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ple_pkg.sv
rtl/ple_if.sv
rtl/ple_ram.sv
rtl/positional_list_engine_unit.sv
sim/positional_list_engine_unit_checker.sv
sim/positional_list_engine_unit_tb.sv
